FILE: hdl/banked_stack_set_macros.svh
// Assertion macros for the banked stack set RTL; included by bss_ctrl.
// Users must have signals named clk and arst_n in scope.
`ifndef BANKED_STACK_SET_MACROS_SVH
`define BANKED_STACK_SET_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/bss_pkg.sv
// Shared types and constants for the banked stack set.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

	localparam int ACTION_W = 2;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 6;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 5;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam action_t ACT_PUSH   = 2'd0;
	localparam action_t ACT_POP    = 2'd1;
	localparam action_t ACT_POP_AT = 2'd2;

	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_EMPTY = 2'd1;
	localparam status_t STAT_FULL  = 2'd2;

	typedef struct packed {
		logic load;
		logic exec;
	} bss_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/bss_ctrl.sv
// Request sequencer for the banked stack set: accept, execute, present result.
// Depends on bss_pkg and banked_stack_set_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "banked_stack_set_macros.svh"

module bss_ctrl
	import bss_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output bss_cmd_t      cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign cmd.load  = in_valid && in_ready;
	assign cmd.exec  = (state_q == S_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`BSS_ASSERT_NEXT(a_accept_executes, in_valid && in_ready, state_q == S_EXEC, "accepted request did not execute")
	`BSS_ASSERT_NEXT(a_exec_gives_result, state_q == S_EXEC, out_valid_q, "executed request gave no result")
	`BSS_ASSERT_NOW(a_exec_slot_free, state_q == S_EXEC, !out_valid_q, "result slot busy during execute")

endmodule

`default_nettype wire

FILE: hdl/bss_datapath.sv
// Datapath of the banked stack set: fill counts, stack selection, plate memory, result.
// Depends on bss_pkg; driven by commands from bss_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module bss_datapath
	import bss_pkg::*;
#(
	parameter int NUM_STACKS   = 64,
	parameter int MAX_CAPACITY = 16,
	parameter int DATA_WIDTH   = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire bss_cmd_t                    cmd,
	input  wire logic                        cfg_we,
	input  wire logic [CFG_W-1:0]            cfg_wdata,
	input  wire logic [ACTION_W-1:0]         action,
	input  wire logic signed [VALUE_W-1:0]   push_value,
	input  wire logic [INDEX_W-1:0]          stack_index,
	output logic [STATUS_W-1:0]              status,
	output logic signed [VALUE_W-1:0]        popped_value
);

	localparam int SW        = $clog2(NUM_STACKS);
	localparam int CW        = $clog2(MAX_CAPACITY + 1);
	localparam int LW        = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
	localparam int DEPTH     = NUM_STACKS * MAX_CAPACITY;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RESET_CAP = (MAX_CAPACITY < 16) ? MAX_CAPACITY : 16;
	localparam logic [AW-1:0] CAP_A = AW'(MAX_CAPACITY);

	logic [DATA_WIDTH-1:0] plate_store [DEPTH];
	logic [CW-1:0]         fill_q [NUM_STACKS];
	logic [CW-1:0]         capacity_q;
	logic [CW-1:0]         cap_next;

	action_t               action_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [INDEX_W-1:0]    index_q;

	logic [DATA_WIDTH-1:0] rd_data_q;
	status_t               status_q;
	logic                  pop_ok_q;

	logic [NUM_STACKS-1:0] nonfull;
	logic [NUM_STACKS-1:0] nonempty;
	logic [NUM_STACKS-1:0] ne_rev;
	logic [NUM_STACKS-1:0] nf_oh;
	logic [NUM_STACKS-1:0] ne_rev_oh;
	logic [NUM_STACKS-1:0] ne_oh;
	logic [NUM_STACKS-1:0] named_oh;
	logic [NUM_STACKS-1:0] sel_oh;
	logic                  found;
	logic [SW-1:0]         sel_idx;
	logic [CW-1:0]         sel_cnt;
	logic [CW-1:0]         lvl_cnt;
	logic [AW-1:0]         addr;
	logic                  is_push;
	logic                  do_push;
	logic                  do_pop;
	status_t               status_next;

	always_comb begin
		if (cfg_wdata == '0) begin
			cap_next = CW'(1);
		end else if (int'(cfg_wdata) > MAX_CAPACITY) begin
			cap_next = CW'(MAX_CAPACITY);
		end else begin
			cap_next = CW'(cfg_wdata);
		end
	end

	always_comb begin
		for (int s = 0; s < NUM_STACKS; s++) begin
			nonfull[s]  = fill_q[s] < capacity_q;
			nonempty[s] = fill_q[s] != '0;
		end
		for (int s = 0; s < NUM_STACKS; s++) begin
			ne_rev[s] = nonempty[NUM_STACKS-1-s];
		end
	end

	// Isolating the lowest set bit gives the priority pick as a one-hot vector.
	assign nf_oh     = nonfull & (~nonfull + NUM_STACKS'(1));
	assign ne_rev_oh = ne_rev & (~ne_rev + NUM_STACKS'(1));
	assign named_oh  = (NUM_STACKS'(1) << index_q) & nonempty;

	always_comb begin
		for (int s = 0; s < NUM_STACKS; s++) begin
			ne_oh[s] = ne_rev_oh[NUM_STACKS-1-s];
		end
	end

	always_comb begin
		case (action_q)
			ACT_PUSH:   sel_oh = nf_oh;
			ACT_POP:    sel_oh = ne_oh;
			ACT_POP_AT: sel_oh = named_oh;
			default:    sel_oh = '0;
		endcase
	end

	always_comb begin
		sel_idx = '0;
		sel_cnt = '0;
		for (int s = 0; s < NUM_STACKS; s++) begin
			if (sel_oh[s]) begin
				sel_idx = sel_idx | SW'(s);
				sel_cnt = sel_cnt | fill_q[s];
			end
		end
	end

	assign found   = |sel_oh;
	assign is_push = (action_q == ACT_PUSH);
	assign do_push = cmd.exec && is_push && found;
	assign do_pop  = cmd.exec && !is_push && found;
	assign lvl_cnt = is_push ? sel_cnt : (sel_cnt - CW'(1));
	assign addr    = AW'(sel_idx) * CAP_A + AW'(LW'(lvl_cnt));

	always_comb begin
		case (action_q)
			ACT_PUSH:   status_next = found ? STAT_OK : STAT_FULL;
			ACT_POP:    status_next = found ? STAT_OK : STAT_EMPTY;
			ACT_POP_AT: status_next = found ? STAT_OK : STAT_EMPTY;
			default:    status_next = STAT_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			value_q  <= DATA_WIDTH'($unsigned(push_value));
			index_q  <= stack_index;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			plate_store[addr] <= value_q;
		end
		if (do_pop) begin
			rd_data_q <= plate_store[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_STACKS; s++) begin
				fill_q[s] <= '0;
			end
			capacity_q <= CW'(RESET_CAP);
			status_q   <= STAT_OK;
			pop_ok_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cap_next;
			end
			for (int s = 0; s < NUM_STACKS; s++) begin
				if (sel_oh[s] && do_push) begin
					fill_q[s] <= fill_q[s] + CW'(1);
				end else if (sel_oh[s] && do_pop) begin
					fill_q[s] <= fill_q[s] - CW'(1);
				end
			end
			if (cmd.exec) begin
				status_q <= status_next;
				pop_ok_q <= !is_push && found;
			end
		end
	end

	assign status       = status_q;
	assign popped_value = pop_ok_q ? VALUE_W'(rd_data_q) : '0;

endmodule

`default_nettype wire

FILE: hdl/banked_stack_set.sv
// Banked stack set: a request is accepted, then executed; the result is valid in
// the cycle after execute, and a new request is taken when it leaves.
// The controller takes no new request while the current one is being executed,
// nor while an earlier result still waits for out_ready.
// Reset clears all fill counts, sets the capacity to min(16, MAX_CAPACITY); plate
// memory is not cleared, since a slot is only read after it has been written.
`timescale 1ns / 1ps
`default_nettype none

module banked_stack_set
	import bss_pkg::*;
#(
	parameter int NUM_STACKS   = 64,
	parameter int MAX_CAPACITY = 16,
	parameter int DATA_WIDTH   = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_W-1:0]          cfg_wdata,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [ACTION_W-1:0]       action,
	input  wire logic signed [VALUE_W-1:0] push_value,
	input  wire logic [INDEX_W-1:0]        stack_index,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [STATUS_W-1:0]            status,
	output logic signed [VALUE_W-1:0]      popped_value
);

	bss_cmd_t cmd;

	bss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	bss_datapath #(
		.NUM_STACKS   (NUM_STACKS),
		.MAX_CAPACITY (MAX_CAPACITY),
		.DATA_WIDTH   (DATA_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.action       (action),
		.push_value   (push_value),
		.stack_index  (stack_index),
		.status       (status),
		.popped_value (popped_value)
	);

endmodule

`default_nettype wire
